@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the plane side classifier core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Boolean cond must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

@@ rtl/core/psc_pkg.sv @@
// Shared types and constants of the plane side classifier.
`default_nettype none

package psc_pkg;

    localparam int NORMAL_WIDTH    = 16;
    localparam int OPCODE_WIDTH    = 2;
    localparam int KIND_WIDTH      = 2;
    localparam int SIDE_WIDTH      = 2;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [OPCODE_WIDTH-1:0] OP_POINT    = 2'd0;
    localparam logic [OPCODE_WIDTH-1:0] OP_TRIANGLE = 2'd1;
    localparam logic [OPCODE_WIDTH-1:0] OP_BOX      = 2'd2;
    localparam logic [OPCODE_WIDTH-1:0] OP_NONE     = 2'd3;

    localparam logic [KIND_WIDTH-1:0] KIND_FINITE   = 2'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_NULL     = 2'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_INFINITE = 2'd2;

    localparam logic [SIDE_WIDTH-1:0] SIDE_ON   = 2'd0;
    localparam logic [SIDE_WIDTH-1:0] SIDE_POS  = 2'd1;
    localparam logic [SIDE_WIDTH-1:0] SIDE_NEG  = 2'd2;
    localparam logic [SIDE_WIDTH-1:0] SIDE_BOTH = 2'd3;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NORMAL_X     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NORMAL_Y     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NORMAL_Z     = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PLANE_OFFSET = 2'd3;

    // Load strobes and mode for one distance lane.
    typedef struct packed {
        logic load_prod;
        logic load_sum;
        logic abs_mode;
    } lane_ctrl_t;

    // Accumulator width: products are NORMAL_WIDTH+coord+2 bits, offset is
    // coord+frac bits, plus headroom for a four-term sum.
    function automatic int acc_width(input int coord_w, input int frac_w);
        int prod_w;
        int off_w;
        prod_w = NORMAL_WIDTH + coord_w + 2;
        off_w  = coord_w + frac_w;
        return ((prod_w > off_w) ? prod_w : off_w) + 2;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/psc_in_if.sv @@
// Input item channel of the plane side classifier.
`default_nettype none

interface psc_in_if #(
    parameter int COORD_WIDTH = 32
);
    import psc_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [OPCODE_WIDTH-1:0]       opcode;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] a_z;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic signed [COORD_WIDTH-1:0] b_z;
    logic signed [COORD_WIDTH-1:0] c_x;
    logic signed [COORD_WIDTH-1:0] c_y;
    logic signed [COORD_WIDTH-1:0] c_z;
    logic [KIND_WIDTH-1:0]         box_kind;

    modport source (
        output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, box_kind,
        input  ready
    );

    modport sink (
        input  valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, box_kind,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/core/psc_out_if.sv @@
// Result item channel of the plane side classifier.
`default_nettype none

interface psc_out_if;
    import psc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SIDE_WIDTH-1:0] side;

    modport source (
        output valid, side,
        input  ready
    );

    modport sink (
        input  valid, side,
        output ready
    );

endinterface

`default_nettype wire

@@ rtl/core/plane_side_classifier_core.sv @@
// Top level of the plane side classifier: config registers, lanes, merge, output.
//
//  channel    | dir | handshake          | payload
//  -----------+-----+--------------------+------------------------------------------
//  in_item    | in  | valid / ready      | opcode, a_*, b_*, c_*, box_kind
//  out_item   | out | valid / ready      | side
//  cfg        | in  | cfg_we, no wait    | cfg_index, cfg_wdata
//
//  One item per cycle while out_item.ready is high; an accepted item passes
//  the multiply stage and the sum stage, then is classified into the output register.
//  Each stage advances when the one after it is empty or moving, so bubbles
//  fill up under an output stall; in_item.ready drops only when all three
//  stages hold items and out_item.ready is low.
//  Reset clears the plane registers to zero and empties the pipeline.
`default_nettype none

`include "assert_macros.svh"

module plane_side_classifier_core #(
    parameter int COORD_WIDTH      = 32,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    psc_in_if.sink                               in_item,
    psc_out_if.source                            out_item,
    input  logic                                 cfg_we,
    input  logic [psc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_wdata
);
    import psc_pkg::*;

    localparam int ACC_WIDTH = acc_width(COORD_WIDTH, NORMAL_FRAC_BITS);

    // Plane registers.
    logic signed [NORMAL_WIDTH-1:0] normal_x_reg;
    logic signed [NORMAL_WIDTH-1:0] normal_y_reg;
    logic signed [NORMAL_WIDTH-1:0] normal_z_reg;
    logic signed [COORD_WIDTH-1:0]  offset_reg;

    // Pipeline valid bits and stage enables.
    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic en1;
    logic en2;
    logic en3;

    // Item tags carried beside the lanes.
    logic [OPCODE_WIDTH-1:0] op1_reg;
    logic [OPCODE_WIDTH-1:0] op2_reg;
    logic [KIND_WIDTH-1:0]   kind1_reg;
    logic [KIND_WIDTH-1:0]   kind2_reg;

    lane_ctrl_t               ctrl_pt;
    lane_ctrl_t               ctrl_b;
    logic signed [ACC_WIDTH-1:0] dist_a;
    logic signed [ACC_WIDTH-1:0] dist_b;
    logic signed [ACC_WIDTH-1:0] dist_c;
    logic [SIDE_WIDTH-1:0]    side_next;
    logic [SIDE_WIDTH-1:0]    side_reg;

    // Config writes; the user must write only while no item is in flight, the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg <= '0;
            normal_y_reg <= '0;
            normal_z_reg <= '0;
            offset_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NORMAL_X:     normal_x_reg <= cfg_wdata[NORMAL_WIDTH-1:0];
                CFG_NORMAL_Y:     normal_y_reg <= cfg_wdata[NORMAL_WIDTH-1:0];
                CFG_NORMAL_Z:     normal_z_reg <= cfg_wdata[NORMAL_WIDTH-1:0];
                CFG_PLANE_OFFSET: offset_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // A stage moves when its successor is empty or moving on.
    assign en3 = !v3_reg || out_item.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_item.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_item.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            op1_reg   <= in_item.opcode;
            kind1_reg <= in_item.box_kind;
        end
        if (en2)
        begin
            op2_reg   <= op1_reg;
            kind2_reg <= kind1_reg;
        end
        if (en3)
        begin
            side_reg  <= side_next;
        end
    end

    // Lanes a and c always take point distances; lane b switches to the box
    // extent sum(|n|*|h|) on a box item.
    assign ctrl_pt.load_prod = en1;
    assign ctrl_pt.load_sum  = en2;
    assign ctrl_pt.abs_mode  = 1'b0;
    assign ctrl_b.load_prod  = en1;
    assign ctrl_b.load_sum   = en2;
    assign ctrl_b.abs_mode   = (in_item.opcode == OP_BOX);

    psc_lane #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
        .ACC_WIDTH        (ACC_WIDTH)
    ) u_lane_a (
        .clk          (clk),
        .ctrl         (ctrl_pt),
        .normal_x     (normal_x_reg),
        .normal_y     (normal_y_reg),
        .normal_z     (normal_z_reg),
        .plane_offset (offset_reg),
        .pos_x        (in_item.a_x),
        .pos_y        (in_item.a_y),
        .pos_z        (in_item.a_z),
        .lane_dist    (dist_a)
    );

    psc_lane #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
        .ACC_WIDTH        (ACC_WIDTH)
    ) u_lane_b (
        .clk          (clk),
        .ctrl         (ctrl_b),
        .normal_x     (normal_x_reg),
        .normal_y     (normal_y_reg),
        .normal_z     (normal_z_reg),
        .plane_offset (offset_reg),
        .pos_x        (in_item.b_x),
        .pos_y        (in_item.b_y),
        .pos_z        (in_item.b_z),
        .lane_dist    (dist_b)
    );

    psc_lane #(
        .COORD_WIDTH      (COORD_WIDTH),
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS),
        .ACC_WIDTH        (ACC_WIDTH)
    ) u_lane_c (
        .clk          (clk),
        .ctrl         (ctrl_pt),
        .normal_x     (normal_x_reg),
        .normal_y     (normal_y_reg),
        .normal_z     (normal_z_reg),
        .plane_offset (offset_reg),
        .pos_x        (in_item.c_x),
        .pos_y        (in_item.c_y),
        .pos_z        (in_item.c_z),
        .lane_dist    (dist_c)
    );

    psc_merge #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_merge (
        .opcode   (op2_reg),
        .box_kind (kind2_reg),
        .dist_a   (dist_a),
        .dist_b   (dist_b),
        .dist_c   (dist_c),
        .side     (side_next)
    );

    assign out_item.valid = v3_reg;
    assign out_item.side  = side_reg;

    // Backpressure only when every stage is full and the output is stalled.
    `ASSERT_PROP(a_full_stall, clk, rst_n,
        !in_item.ready |-> (v1_reg && v2_reg && v3_reg && !out_item.ready),
        "input stalled with room in the pipeline")
    // The box extent from lane b is a magnitude sum.
    `ASSERT_NEVER(a_extent_sign, clk, rst_n,
        v2_reg && (op2_reg == OP_BOX) && dist_b[ACC_WIDTH-1],
        "negative box extent")
    // An unused opcode lands in the output register as on-plane.
    `ASSERT_PROP(a_unused_op, clk, rst_n,
        (en3 && v2_reg && (op2_reg == OP_NONE)) |=> (side_reg == SIDE_ON),
        "unused opcode gave a side")

endmodule

`default_nettype wire

@@ rtl/core/psc_lane.sv @@
// One distance lane: three products, then the sum with the plane offset.
`default_nettype none

module psc_lane #(
    parameter int COORD_WIDTH      = 32,
    parameter int NORMAL_FRAC_BITS = 14,
    parameter int ACC_WIDTH        = 52
) (
    input  logic                                     clk,
    input  psc_pkg::lane_ctrl_t                      ctrl,
    input  logic signed [psc_pkg::NORMAL_WIDTH-1:0]  normal_x,
    input  logic signed [psc_pkg::NORMAL_WIDTH-1:0]  normal_y,
    input  logic signed [psc_pkg::NORMAL_WIDTH-1:0]  normal_z,
    input  logic signed [COORD_WIDTH-1:0]            plane_offset,
    input  logic signed [COORD_WIDTH-1:0]            pos_x,
    input  logic signed [COORD_WIDTH-1:0]            pos_y,
    input  logic signed [COORD_WIDTH-1:0]            pos_z,
    output logic signed [ACC_WIDTH-1:0]              lane_dist
);
    import psc_pkg::*;

    localparam int PROD_WIDTH = NORMAL_WIDTH + COORD_WIDTH + 2;

    logic signed [NORMAL_WIDTH-1:0] n_in [3];
    logic signed [COORD_WIDTH-1:0]  c_in [3];
    logic signed [NORMAL_WIDTH:0]   n_op [3];
    logic signed [COORD_WIDTH:0]    c_op [3];
    logic [NORMAL_WIDTH-1:0]        n_mag [3];
    logic [COORD_WIDTH-1:0]         c_mag [3];
    logic signed [PROD_WIDTH-1:0]   prod_next [3];
    logic signed [PROD_WIDTH-1:0]   prod_reg  [3];
    logic                           abs_reg;
    logic signed [ACC_WIDTH-1:0]    offset_term;
    logic signed [ACC_WIDTH-1:0]    dist_next;
    logic signed [ACC_WIDTH-1:0]    dist_reg;

    assign n_in[0] = normal_x;
    assign n_in[1] = normal_y;
    assign n_in[2] = normal_z;
    assign c_in[0] = pos_x;
    assign c_in[1] = pos_y;
    assign c_in[2] = pos_z;

    // Magnitude mode multiplies |n| by |h| for the box extent.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_mag[i] = n_in[i][NORMAL_WIDTH-1] ? (~n_in[i] + 1'b1) : n_in[i];
            c_mag[i] = c_in[i][COORD_WIDTH-1] ? (~c_in[i] + 1'b1) : c_in[i];
            n_op[i]  = ctrl.abs_mode ? {1'b0, n_mag[i]} : {n_in[i][NORMAL_WIDTH-1], n_in[i]};
            c_op[i]  = ctrl.abs_mode ? {1'b0, c_mag[i]} : {c_in[i][COORD_WIDTH-1], c_in[i]};
            prod_next[i] = n_op[i] * c_op[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_prod)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
            abs_reg <= ctrl.abs_mode;
        end
    end

    // Offset lined up with the product fraction; left out for the extent.
    assign offset_term = abs_reg ? '0 :
        {{(ACC_WIDTH-COORD_WIDTH-NORMAL_FRAC_BITS){plane_offset[COORD_WIDTH-1]}},
         plane_offset, {NORMAL_FRAC_BITS{1'b0}}};

    assign dist_next = offset_term
        + {{(ACC_WIDTH-PROD_WIDTH){prod_reg[0][PROD_WIDTH-1]}}, prod_reg[0]}
        + {{(ACC_WIDTH-PROD_WIDTH){prod_reg[1][PROD_WIDTH-1]}}, prod_reg[1]}
        + {{(ACC_WIDTH-PROD_WIDTH){prod_reg[2][PROD_WIDTH-1]}}, prod_reg[2]};

    always_ff @(posedge clk)
    begin
        if (ctrl.load_sum)
        begin
            dist_reg <= dist_next;
        end
    end

    assign lane_dist = dist_reg;

endmodule

`default_nettype wire

@@ rtl/core/psc_merge.sv @@
// Merge stage: turns the lane distances into the side code.
`default_nettype none

module psc_merge #(
    parameter int ACC_WIDTH = 52
) (
    input  logic [psc_pkg::OPCODE_WIDTH-1:0] opcode,
    input  logic [psc_pkg::KIND_WIDTH-1:0]   box_kind,
    input  logic signed [ACC_WIDTH-1:0]      dist_a,
    input  logic signed [ACC_WIDTH-1:0]      dist_b,
    input  logic signed [ACC_WIDTH-1:0]      dist_c,
    output logic [psc_pkg::SIDE_WIDTH-1:0]   side
);
    import psc_pkg::*;

    logic [SIDE_WIDTH-1:0]      side_a;
    logic [SIDE_WIDTH-1:0]      side_b;
    logic [SIDE_WIDTH-1:0]      side_c;
    logic [SIDE_WIDTH-1:0]      box_side;
    logic signed [ACC_WIDTH:0]  box_lo;
    logic signed [ACC_WIDTH:0]  box_hi;

    assign side_a = (dist_a == '0) ? SIDE_ON : (dist_a[ACC_WIDTH-1] ? SIDE_NEG : SIDE_POS);
    assign side_b = (dist_b == '0) ? SIDE_ON : (dist_b[ACC_WIDTH-1] ? SIDE_NEG : SIDE_POS);
    assign side_c = (dist_c == '0) ? SIDE_ON : (dist_c[ACC_WIDTH-1] ? SIDE_NEG : SIDE_POS);

    // dist_b holds the extent m in box mode.
    assign box_lo = {dist_a[ACC_WIDTH-1], dist_a} + {dist_b[ACC_WIDTH-1], dist_b};
    assign box_hi = {dist_a[ACC_WIDTH-1], dist_a} - {dist_b[ACC_WIDTH-1], dist_b};

    always_comb
    begin
        if (box_lo[ACC_WIDTH])
        begin
            box_side = SIDE_NEG;
        end
        else if (!box_hi[ACC_WIDTH] && (box_hi != '0))
        begin
            box_side = SIDE_POS;
        end
        else
        begin
            box_side = SIDE_BOTH;
        end
    end

    always_comb
    begin
        case (opcode)
            OP_POINT:
            begin
                side = side_a;
            end
            OP_TRIANGLE:
            begin
                if ((side_a == SIDE_ON) || (side_b == SIDE_ON) || (side_c == SIDE_ON))
                begin
                    side = SIDE_BOTH;
                end
                else
                begin
                    side = side_a | side_b | side_c;
                end
            end
            OP_BOX:
            begin
                case (box_kind)
                    KIND_NULL:     side = SIDE_ON;
                    KIND_INFINITE: side = SIDE_BOTH;
                    default:       side = box_side;
                endcase
            end
            default:
            begin
                side = SIDE_ON;
            end
        endcase
    end

endmodule

`default_nettype wire
